// ----- hdl/swing_cycle_counter_assert.svh -----
// Assertion macros shared by the swing cycle counter modules.
`ifndef SWING_CYCLE_COUNTER_ASSERT_SVH
`define SWING_CYCLE_COUNTER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check prop at every rising clk_i edge outside reset.
`define SCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that post holds in the cycle after pre.
`define SCC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define SCC_ASSERT(lbl, prop, msg)
`define SCC_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ----- hdl/scc_pkg.sv -----
// Package with types, codes and constants of the swing cycle counter.
`default_nettype none
package scc_pkg;

  localparam int unsigned PositionBits = 24;
  localparam int unsigned DistW        = 23;
  localparam int unsigned CountW       = 8;
  localparam int unsigned LimitW       = 16;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned SqW          = 2 * DistW;

  localparam logic [DistW-1:0]  MaxDistRst   = 23'd60000;
  localparam logic [DistW-1:0]  MinDistRst   = 23'd20000;
  localparam logic [CountW-1:0] SwingCntRst  = 8'd3;
  localparam logic [DistW-1:0]  StillDistRst = 23'd3000;
  localparam logic [LimitW-1:0] StillLimRst  = 16'd500;
  localparam logic [LimitW-1:0] ExitLimRst   = 16'd50;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_DIST   = 3'd0,
    CFG_MIN_DIST   = 3'd1,
    CFG_SWING_CNT  = 3'd2,
    CFG_STILL_DIST = 3'd3,
    CFG_STILL_LIM  = 3'd4,
    CFG_EXIT_LIM   = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OP_JUDGE = 1'b0,
    OP_EXIT  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_OUT   = 2'd1,
    PH_ARMED = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    RSN_NONE   = 2'd0,
    RSN_STILL  = 2'd1,
    RSN_SWINGS = 2'd2
  } reason_e;

  typedef struct packed {
    logic [DistW-1:0]  max_dist;
    logic [DistW-1:0]  min_dist;
    logic [CountW-1:0] swing_cnt;
    logic [DistW-1:0]  still_dist;
    logic [LimitW-1:0] still_lim;
    logic [LimitW-1:0] exit_lim;
  } cfg_t;

  typedef struct packed {
    logic still;
    logic above_hi;
    logic above_lo;
    logic below_lo;
  } dist_flags_t;

  typedef struct packed {
    logic              origin_captured;
    logic              done_res;
    logic [1:0]        done_reason;
    logic              exit_ready;
    logic [1:0]        swing_phase;
    logic [CountW-1:0] swings_left;
  } res_t;

endpackage
`default_nettype wire

// ----- hdl/scc_in_if.sv -----
// Sample request channel: valid, ready and one position sample.
`default_nettype none
interface scc_in_if
  import scc_pkg::*;
#(
  parameter int unsigned POSITION_BITS = PositionBits
);
  logic                            valid;
  logic                            ready;
  logic                            opcode;
  logic signed [POSITION_BITS-1:0] pos_x;
  logic signed [POSITION_BITS-1:0] pos_z;

  modport source (output valid, output opcode, output pos_x, output pos_z, input ready);
  modport sink   (input valid, input opcode, input pos_x, input pos_z, output ready);
endinterface
`default_nettype wire

// ----- hdl/scc_out_if.sv -----
// Result request channel: valid, ready and one swing status result.
`default_nettype none
interface scc_out_if
  import scc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              origin_captured;
  logic              done_res;
  logic [1:0]        done_reason;
  logic              exit_ready;
  logic [1:0]        swing_phase;
  logic [CountW-1:0] swings_left;

  modport source (
    output valid, output origin_captured, output done_res, output done_reason,
    output exit_ready, output swing_phase, output swings_left, input ready
  );
  modport sink (
    input valid, input origin_captured, input done_res, input done_reason,
    input exit_ready, input swing_phase, input swings_left, output ready
  );
endinterface
`default_nettype wire

// ----- hdl/scc_dist.sv -----
// Squared planar distance from the origin, compared with squared thresholds.
`default_nettype none
module scc_dist
  import scc_pkg::*;
#(
  parameter int unsigned POSITION_BITS = PositionBits
) (
  input  wire logic signed [POSITION_BITS-1:0] pos_x_i,
  input  wire logic signed [POSITION_BITS-1:0] pos_z_i,
  input  wire logic signed [POSITION_BITS-1:0] org_x_i,
  input  wire logic signed [POSITION_BITS-1:0] org_z_i,
  input  wire logic [DistW-1:0]                max_dist_i,
  input  wire logic [DistW-1:0]                low_dist_i,
  input  wire logic [DistW-1:0]                still_dist_i,
  output dist_flags_t                          flags_o
);
  localparam int unsigned P    = POSITION_BITS;
  localparam int unsigned D2W  = 2 * P + 1;
  localparam int unsigned CmpW = (D2W > SqW) ? D2W : SqW;

  logic signed [P:0] diff_x, diff_z, neg_x, neg_z;
  logic [P-1:0]      mag_x, mag_z;
  logic [2*P-1:0]    wide_x, wide_z, sq_x, sq_z;
  logic [D2W-1:0]    d2;
  logic [SqW-1:0]    hi2, lo2, st2;
  logic [CmpW-1:0]   d2_c, hi2_c, lo2_c, st2_c;

  // Sign-extend by one bit so the difference cannot overflow.
  assign diff_x = $signed({pos_x_i[P-1], pos_x_i}) - $signed({org_x_i[P-1], org_x_i});
  assign diff_z = $signed({pos_z_i[P-1], pos_z_i}) - $signed({org_z_i[P-1], org_z_i});
  assign neg_x  = -diff_x;
  assign neg_z  = -diff_z;
  assign mag_x  = diff_x[P] ? neg_x[P-1:0] : diff_x[P-1:0];
  assign mag_z  = diff_z[P] ? neg_z[P-1:0] : diff_z[P-1:0];

  assign wide_x = {{P{1'b0}}, mag_x};
  assign wide_z = {{P{1'b0}}, mag_z};
  assign sq_x   = wide_x * wide_x;
  assign sq_z   = wide_z * wide_z;
  assign d2     = {1'b0, sq_x} + {1'b0, sq_z};

  assign hi2 = {{DistW{1'b0}}, max_dist_i} * {{DistW{1'b0}}, max_dist_i};
  assign lo2 = {{DistW{1'b0}}, low_dist_i} * {{DistW{1'b0}}, low_dist_i};
  assign st2 = {{DistW{1'b0}}, still_dist_i} * {{DistW{1'b0}}, still_dist_i};

  assign d2_c  = CmpW'(d2);
  assign hi2_c = CmpW'(hi2);
  assign lo2_c = CmpW'(lo2);
  assign st2_c = CmpW'(st2);

  assign flags_o.still    = d2_c < st2_c;
  assign flags_o.above_hi = d2_c > hi2_c;
  assign flags_o.above_lo = d2_c > lo2_c;
  assign flags_o.below_lo = d2_c < lo2_c;
endmodule
`default_nettype wire

// ----- hdl/scc_core.sv -----
// Origin, swing phase, swing count and stillness state with the per-sample update.
`default_nettype none
`include "swing_cycle_counter_assert.svh"
module scc_core
  import scc_pkg::*;
#(
  parameter int unsigned POSITION_BITS = PositionBits
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            step_i,
  input  wire logic                            opcode_i,
  input  wire logic signed [POSITION_BITS-1:0] pos_x_i,
  input  wire logic signed [POSITION_BITS-1:0] pos_z_i,
  input  cfg_t                                 cfg_i,
  output res_t                                 res_o
);
  localparam int unsigned P = POSITION_BITS;

  logic                origin_valid_q, origin_valid_d;
  logic signed [P-1:0] org_x_q, org_x_d, org_z_q, org_z_d;
  phase_e              phase_q, phase_d;
  logic [CountW-1:0]   rem_q, rem_d;
  logic [DistW-1:0]    low_q, low_d;
  logic [LimitW-1:0]   still_q, still_d, still_inc;
  dist_flags_t         flags;
  res_t                res;

  scc_dist #(.POSITION_BITS(P)) u_dist (
    .pos_x_i      (pos_x_i),
    .pos_z_i      (pos_z_i),
    .org_x_i      (org_x_q),
    .org_z_i      (org_z_q),
    .max_dist_i   (cfg_i.max_dist),
    .low_dist_i   (low_q),
    .still_dist_i (cfg_i.still_dist),
    .flags_o      (flags)
  );

  assign still_inc = (still_q == {LimitW{1'b1}}) ? still_q : still_q + LimitW'(1);

  always_comb begin
    origin_valid_d = origin_valid_q;
    org_x_d        = org_x_q;
    org_z_d        = org_z_q;
    phase_d        = phase_q;
    rem_d          = rem_q;
    low_d          = low_q;
    still_d        = still_q;
    res            = '0;
    if (!origin_valid_q) begin
      // First sample: latch origin, load swings and low threshold.
      origin_valid_d      = 1'b1;
      org_x_d             = pos_x_i;
      org_z_d             = pos_z_i;
      rem_d               = cfg_i.swing_cnt;
      low_d               = cfg_i.min_dist;
      res.origin_captured = 1'b1;
    end else if (opcode_i == OP_JUDGE) begin
      still_d = flags.still ? still_inc : '0;
      // Phase steps chain within one sample; the low test uses the old threshold.
      if (phase_d == PH_IDLE && flags.above_hi) phase_d = PH_OUT;
      if (phase_d == PH_OUT && flags.above_lo) phase_d = PH_ARMED;
      if (phase_d == PH_ARMED && flags.below_lo) begin
        phase_d = PH_IDLE;
        if (rem_d != '0) rem_d = rem_d - CountW'(1);
        if (rem_d == CountW'(1)) low_d = cfg_i.still_dist;
      end
      if (still_d > cfg_i.still_lim) begin
        res.done_res    = 1'b1;
        res.done_reason = RSN_STILL;
      end else if (rem_d == '0) begin
        res.done_res    = 1'b1;
        res.done_reason = RSN_SWINGS;
        still_d         = '0;
      end
    end else begin
      // Exit wait: count stillness only, release once past the exit limit.
      if (flags.still) still_d = still_inc;
      if (still_d > cfg_i.exit_lim) begin
        phase_d        = PH_IDLE;
        still_d        = '0;
        res.exit_ready = 1'b1;
      end
    end
    res.swing_phase = phase_d;
    res.swings_left = rem_d;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_valid_q <= 1'b0;
      org_x_q        <= '0;
      org_z_q        <= '0;
      phase_q        <= PH_IDLE;
      rem_q          <= '0;
      low_q          <= '0;
      still_q        <= '0;
    end else if (step_i) begin
      origin_valid_q <= origin_valid_d;
      org_x_q        <= org_x_d;
      org_z_q        <= org_z_d;
      phase_q        <= phase_d;
      rem_q          <= rem_d;
      low_q          <= low_d;
      still_q        <= still_d;
    end
  end

  `SCC_ASSERT_NEXT(a_origin_sticky, origin_valid_q, origin_valid_q, "origin lost after capture")
  `SCC_ASSERT(a_done_alone, step_i && res.done_res |-> !res.exit_ready && !res.origin_captured, "done together with exit or capture")
  `SCC_ASSERT(a_reason_done, step_i |-> (res.done_res == (res.done_reason != RSN_NONE)), "done reason disagrees with done flag")
endmodule
`default_nettype wire

// ----- hdl/swing_cycle_counter.sv -----
// Top level of the swing cycle counter: config registers, sample stage and result register.
`default_nettype none
`include "swing_cycle_counter_assert.svh"
// Swing cycle counter. Each request on in_i carries one position sample (opcode,
// pos_x, pos_z in signed micrometres) and yields exactly one result on out_o, in
// order. The first sample after reset latches the origin and loads the swing count
// and low threshold from the config registers; later judge samples run the
// out/armed/counted hysteresis on the squared distance from the origin and report
// done on stillness timeout or when no swings remain, while exit-wait samples count
// stillness and clear the phase once past the exit limit. Throughput is one sample
// per cycle unless out_o stalls: the sample register feeds the distance squarers,
// compares and state update, all combinational, written back to the state registers
// at the same edge that loads the result register, so the next sample sees the new
// state. A request passes the sample register, then the result register. in_i stays
// ready while the result register holds an untaken result, as long as the sample
// register is free. Config registers (cfg_idx_i 0..5: max_distance, min_distance,
// swing_count, still_distance, still_limit, exit_limit) take effect on the next
// cycle; write them only with no sample in flight. Indexes above 5 are dropped. No
// memories and no clearing pass: the block accepts requests right out of reset.
module swing_cycle_counter
  import scc_pkg::*;
#(
  parameter int unsigned POSITION_BITS = PositionBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [DistW-1:0]   cfg_wdata_i,
  scc_in_if.sink                  in_i,
  scc_out_if.source               out_o
);
  localparam int unsigned P = POSITION_BITS;

  cfg_t                cfg_q;
  logic                s1_valid_q;
  logic                s1_op_q;
  logic signed [P-1:0] s1_x_q, s1_z_q;
  logic                out_valid_q;
  res_t                res_q, res;
  logic                advance, in_take, step;

  // Config decode: one register per index, anything else dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_dist   <= MaxDistRst;
      cfg_q.min_dist   <= MinDistRst;
      cfg_q.swing_cnt  <= SwingCntRst;
      cfg_q.still_dist <= StillDistRst;
      cfg_q.still_lim  <= StillLimRst;
      cfg_q.exit_lim   <= ExitLimRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_DIST:   cfg_q.max_dist   <= cfg_wdata_i;
        CFG_MIN_DIST:   cfg_q.min_dist   <= cfg_wdata_i;
        CFG_SWING_CNT:  cfg_q.swing_cnt  <= cfg_wdata_i[CountW-1:0];
        CFG_STILL_DIST: cfg_q.still_dist <= cfg_wdata_i;
        CFG_STILL_LIM:  cfg_q.still_lim  <= cfg_wdata_i[LimitW-1:0];
        CFG_EXIT_LIM:   cfg_q.exit_lim   <= cfg_wdata_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the pipe whenever the result register is empty or being drained.
  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;
  assign step       = s1_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Sample payload: hold until the next request lands.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_op_q <= in_i.opcode;
      s1_x_q  <= in_i.pos_x;
      s1_z_q  <= in_i.pos_z;
    end
  end

  scc_core #(.POSITION_BITS(P)) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .opcode_i (s1_op_q),
    .pos_x_i  (s1_x_q),
    .pos_z_i  (s1_z_q),
    .cfg_i    (cfg_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.origin_captured = res_q.origin_captured;
  assign out_o.done_res        = res_q.done_res;
  assign out_o.done_reason     = res_q.done_reason;
  assign out_o.exit_ready      = res_q.exit_ready;
  assign out_o.swing_phase     = res_q.swing_phase;
  assign out_o.swings_left     = res_q.swings_left;

  `SCC_ASSERT(a_no_overrun, s1_valid_q && out_valid_q && !out_o.ready |-> !in_i.ready, "sample accepted into a blocked pipe")
  `SCC_ASSERT(a_out_from_stage, $rose(out_valid_q) |-> $past(s1_valid_q), "result appeared without a sample")
  `SCC_ASSERT_NEXT(a_step_loads_out, step, out_valid_q, "stepped sample left no result")
endmodule
`default_nettype wire

// ----- tb/tb_swing_cycle_counter.sv -----
// Self-checking testbench for swing_cycle_counter with a per-sample status predictor.
`timescale 1ns / 1ps
module tb_swing_cycle_counter;
  import scc_pkg::*;

  // Register indexes past the last register; writes there must be dropped.
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

  // Every sample is placed as an offset from this corner: x grows, z shrinks.
  // The first request latches it as origin, so offsets are distances per axis.
  localparam logic signed [PositionBits-1:0] OriginX = 24'sh800000;
  localparam logic signed [PositionBits-1:0] OriginZ = 24'sh7FFFFF;
  localparam int unsigned OffsetMax = (1 << PositionBits) - 1;

  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned StillItems  = 100;
  localparam int unsigned RoundItems  = 170;
  localparam int unsigned MaxReports  = 40;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [DistW-1:0]   cfg_wdata_i;

  scc_in_if #(.POSITION_BITS(PositionBits)) in_ch ();
  scc_out_if out_ch ();

  swing_cycle_counter #(.POSITION_BITS(PositionBits)) dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor copy of the registers and of the swing state.
  cfg_t regs = '{max_dist: MaxDistRst, min_dist: MinDistRst, swing_cnt: SwingCntRst,
                 still_dist: StillDistRst, still_lim: StillLimRst, exit_lim: ExitLimRst};
  logic                            org_valid = 1'b0;
  logic signed [PositionBits-1:0]  org_x = '0;
  logic signed [PositionBits-1:0]  org_z = '0;
  phase_e                          arm_phase = PH_IDLE;
  logic [CountW-1:0]               swings = '0;
  logic [DistW-1:0]                low_dist = '0;
  logic [LimitW-1:0]               still_ct = '0;

  res_t        pending_status[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  bit          idle_on = 1'b1;
  logic        sink_hold = 1'b0;
  event        hold_start;

  // Advance the predictor by one sample and return the status it must produce.
  function automatic res_t predict_status(op_e op, logic signed [PositionBits-1:0] x,
                                          logic signed [PositionBits-1:0] z);
    res_t                      r;
    logic signed [PositionBits:0] ddx, ddz;
    logic [PositionBits:0]     mag_x, mag_z;
    logic [63:0]               d2, hi2, lo2, st2;
    logic                      still;
    r = '0;
    if (!org_valid) begin
      // First request after reset only latches; no distance test at all.
      org_valid = 1'b1;
      org_x = x;
      org_z = z;
      swings = regs.swing_cnt;
      low_dist = regs.min_dist;
      r.origin_captured = 1'b1;
    end else begin
      ddx = (PositionBits + 1)'(x) - (PositionBits + 1)'(org_x);
      ddz = (PositionBits + 1)'(z) - (PositionBits + 1)'(org_z);
      mag_x = ddx[PositionBits] ? -ddx : ddx;
      mag_z = ddz[PositionBits] ? -ddz : ddz;
      d2 = 64'(mag_x) * 64'(mag_x) + 64'(mag_z) * 64'(mag_z);
      hi2 = 64'(regs.max_dist) * 64'(regs.max_dist);
      lo2 = 64'(low_dist) * 64'(low_dist);
      st2 = 64'(regs.still_dist) * 64'(regs.still_dist);
      still = d2 < st2;
      if (op == OP_JUDGE) begin
        if (!still) still_ct = '0;
        else if (still_ct != '1) still_ct++;
        // Steps cascade within one sample: out, then armed, then counted.
        if (arm_phase == PH_IDLE && d2 > hi2) arm_phase = PH_OUT;
        if (arm_phase == PH_OUT && d2 > lo2) arm_phase = PH_ARMED;
        if (arm_phase == PH_ARMED && d2 < lo2) begin
          arm_phase = PH_IDLE;
          if (swings != 0) swings--;
          // Last swing must settle down to the stillness distance.
          if (swings == 1) low_dist = regs.still_dist;
        end
        if (still_ct > regs.still_lim) begin
          r.done_res = 1'b1;
          r.done_reason = RSN_STILL;
        end else if (swings == 0) begin
          r.done_res = 1'b1;
          r.done_reason = RSN_SWINGS;
          still_ct = '0;
        end
      end else begin
        if (still && still_ct != '1) still_ct++;
        if (still_ct > regs.exit_lim) begin
          arm_phase = PH_IDLE;
          still_ct = '0;
          r.exit_ready = 1'b1;
        end
      end
    end
    r.swing_phase = arm_phase;
    r.swings_left = swings;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("%0t: result %0d %s got %0h want %0h", $time, results_seen, what, got, want);
  endtask

  // Offer one sample, after a random gap while idle_on is set, and hold it until the block takes it.
  task automatic send_sample(op_e op, int unsigned dx, int unsigned dz);
    int unsigned                    gap;
    logic signed [PositionBits-1:0] x, z;
    x = OriginX + dx[PositionBits-1:0];
    z = OriginZ - dz[PositionBits-1:0];
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.pos_x  <= x;
    in_ch.pos_z  <= z;
    // Registers stay put while a request is in flight, so predict now.
    pending_status.push_back(predict_status(op, x, z));
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Drop valid and hold until every pending result has been taken.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_status.size() != 0);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DistW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_MAX_DIST:   regs.max_dist   = data;
      CFG_MIN_DIST:   regs.min_dist   = data;
      CFG_SWING_CNT:  regs.swing_cnt  = data[CountW-1:0];
      CFG_STILL_DIST: regs.still_dist = data;
      CFG_STILL_LIM:  regs.still_lim  = data[LimitW-1:0];
      CFG_EXIT_LIM:   regs.exit_lim   = data[LimitW-1:0];
      default: ;
    endcase
  endtask

  task automatic close_reg_writes();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(cfg_t s);
    write_reg(CFG_MAX_DIST, s.max_dist);
    write_reg(CFG_MIN_DIST, s.min_dist);
    write_reg(CFG_SWING_CNT, DistW'(s.swing_cnt));
    write_reg(CFG_STILL_DIST, s.still_dist);
    write_reg(CFG_STILL_LIM, DistW'(s.still_lim));
    write_reg(CFG_EXIT_LIM, DistW'(s.exit_lim));
    close_reg_writes();
  endtask

  // Mostly well-formed swings, stillness runs and exit waits, with some noise.
  task automatic send_random_burst(int unsigned count);
    int unsigned sent, kind, reps, reach, top, inner;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      reach = (regs.max_dist > low_dist) ? 32'(regs.max_dist) : 32'(low_dist);
      if (kind < 55) begin
        // Go out past both thresholds, wander, then fall back inside the low one.
        top = reach + 1 + $urandom_range(0, 20000);
        if (top > OffsetMax) top = OffsetMax;
        send_sample(OP_JUDGE, $urandom_range(reach + 1, top), $urandom_range(0, reach));
        reps = $urandom_range(0, 2);
        repeat (reps) send_sample(OP_JUDGE, $urandom_range(0, reach), $urandom_range(0, reach));
        inner = 32'(low_dist) * 7 / 10;
        send_sample(OP_JUDGE, $urandom_range(0, inner), $urandom_range(0, inner));
        sent += reps + 2;
      end else if (kind < 85) begin
        // Hold near the origin: judge samples for timeout, exit samples for exit.
        inner = 32'(regs.still_dist) * 7 / 10;
        reps = (kind < 70) ? $urandom_range(1, 8) : $urandom_range(1, 12);
        repeat (reps)
          send_sample((kind < 70) ? OP_JUDGE : OP_EXIT,
                      $urandom_range(0, inner), $urandom_range(0, inner));
        sent += reps;
      end else begin
        send_sample(op_e'($urandom_range(0, 1)),
                    $urandom_range(0, OffsetMax), $urandom_range(0, OffsetMax));
        sent++;
      end
    end
  endtask

  // Load the registers before capture, with masked and dropped writes mixed in,
  // then latch the origin with an exit-wait sample and follow it with a judge sample.
  task automatic test_origin_capture();
    write_reg(CFG_MAX_DIST, 23'd1000);
    write_reg(CFG_MIN_DIST, 23'd20000);
    write_reg(CFG_SWING_CNT, 23'h5AA564);
    write_reg(CfgIdxSpareLo, 23'h7FFFFF);
    write_reg(CFG_STILL_DIST, 23'd3000);
    write_reg(CfgIdxSpareHi, 23'h000000);
    write_reg(CFG_STILL_LIM, 23'h7F0000);
    write_reg(CFG_EXIT_LIM, 23'h550000);
    close_reg_writes();
    send_sample(OP_EXIT, 0, 0);
    send_sample(OP_JUDGE, 0, 0);
  endtask

  // Hit each threshold exactly and one past it; with the low threshold above the high
  // one, the out phase holds until the low threshold is passed.
  task automatic test_threshold_edges();
    send_sample(OP_JUDGE, 1000, 0);
    send_sample(OP_JUDGE, 1001, 0);
    send_sample(OP_JUDGE, 20000, 0);
    send_sample(OP_JUDGE, 20001, 0);
    send_sample(OP_JUDGE, 20000, 0);
    send_sample(OP_JUDGE, 19999, 0);
    send_sample(OP_JUDGE, 2999, 0);
    send_sample(OP_JUDGE, 3000, 0);
    wait_drained();
    write_reg(CFG_MAX_DIST, '1);
    close_reg_writes();
    // Far corner, then exit-wait clearing an armed phase.
    send_sample(OP_JUDGE, OffsetMax, OffsetMax);
    send_sample(OP_EXIT, 0, 0);
    send_sample(OP_JUDGE, OffsetMax, OffsetMax);
    send_sample(OP_JUDGE, 0, 0);
    send_sample(OP_EXIT, OffsetMax, 0);
    send_sample(OP_EXIT, 0, OffsetMax);
  endtask

  // Stall the result side long enough for the input to back up.
  task automatic test_receiver_hold();
    idle_on = 1'b0;
    -> hold_start;
    send_random_burst(40);
    idle_on = 1'b1;
  endtask

  // Build a stillness run with both limits out of reach, then set each limit to
  // the running count so the next judge and exit-wait samples cross it by one.
  task automatic test_still_limits();
    cfg_t s;
    wait_drained();
    s = regs;
    s.still_dist = 23'd3000;
    s.still_lim = '1;
    s.exit_lim = '1;
    apply_settings(s);
    idle_on = 1'b0;
    repeat (StillItems) send_sample(OP_EXIT, 0, 0);
    wait_drained();
    s.still_lim = still_ct;
    apply_settings(s);
    send_sample(OP_JUDGE, 0, 0);
    wait_drained();
    s.exit_lim = still_ct;
    apply_settings(s);
    send_sample(OP_EXIT, 0, 0);
    idle_on = 1'b1;
  endtask

  // Random traffic across several register settings, both extremes among them.
  task automatic test_random_rounds();
    cfg_t s;
    for (int round_no = 0; round_no < 6; round_no++) begin
      wait_drained();
      s.max_dist   = DistW'($urandom_range(1000, 100000));
      s.min_dist   = DistW'($urandom_range(0, (1 << DistW) - 1));
      s.swing_cnt  = CountW'($urandom_range(0, 255));
      s.still_dist = DistW'($urandom_range(500, 8000));
      s.still_lim  = LimitW'($urandom_range(0, 20));
      s.exit_lim   = LimitW'($urandom_range(0, 10));
      if (round_no == 2) s = '1;
      if (round_no == 3) s = '0;
      apply_settings(s);
      idle_on = (round_no != 4);
      send_random_burst(RoundItems);
    end
    idle_on = 1'b1;
  endtask

  // Result side: check each taken result against the oldest prediction, then
  // draw how long to hold ready low before the next one.
  initial begin : result_sink
    int unsigned gap;
    res_t        got, want;
    out_ch.ready <= 1'b0;
    gap = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        got = {out_ch.origin_captured, out_ch.done_res, out_ch.done_reason,
               out_ch.exit_ready, out_ch.swing_phase, out_ch.swings_left};
        results_seen++;
        if (pending_status.size() == 0) begin
          report_mismatch("result with no request pending", 8'd1, 8'd0);
        end else begin
          want = pending_status.pop_front();
          if (got.origin_captured !== want.origin_captured)
            report_mismatch("origin_captured", 8'(got.origin_captured), 8'(want.origin_captured));
          if (got.done_res !== want.done_res)
            report_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
          if (got.done_reason !== want.done_reason)
            report_mismatch("done_reason", 8'(got.done_reason), 8'(want.done_reason));
          if (got.exit_ready !== want.exit_ready)
            report_mismatch("exit_ready", 8'(got.exit_ready), 8'(want.exit_ready));
          if (got.swing_phase !== want.swing_phase)
            report_mismatch("swing_phase", 8'(got.swing_phase), 8'(want.swing_phase));
          if (got.swings_left !== want.swings_left)
            report_mismatch("swings_left", got.swings_left, want.swings_left);
        end
        gap = idle_on ? $urandom_range(0, 10) : 0;
      end
      if (sink_hold) begin
        out_ch.ready <= 1'b0;
      end else if (gap != 0) begin
        gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering.
  initial begin : receiver_hold
    forever begin
      @(hold_start);
      sink_hold <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      sink_hold <= 1'b0;
    end
  end

  // End the run when no request moves on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no request moved for %0d cycles", StallLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CFG_MAX_DIST;
    cfg_wdata_i  <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.opcode <= OP_JUDGE;
    in_ch.pos_x  <= '0;
    in_ch.pos_z  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_origin_capture();
    test_threshold_edges();
    test_receiver_hold();
    test_still_limits();
    test_random_rounds();

    // Let the last results out, then idle for DrainCycles so stray ones show up.
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/scc_pkg.sv
hdl/scc_in_if.sv
hdl/scc_out_if.sv
hdl/scc_dist.sv
hdl/scc_core.sv
hdl/swing_cycle_counter.sv
tb/tb_swing_cycle_counter.sv
